// File: src/free_block_fit_search_macros.svh
// Assertion macros for the free block fit search.
// Used by files that assert; relies on clk and rst_n in the including module.
`ifndef FREE_BLOCK_FIT_SEARCH_MACROS_SVH
`define FREE_BLOCK_FIT_SEARCH_MACROS_SVH

`ifndef SYNTHESIS
`define FBFS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define FBFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FBFS_ASSERT(label, prop, msg)
`define FBFS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: src/fbfs_pkg.sv
// Package for the free block fit search: defaults, codes, payload and control types.
// No dependencies.
package fbfs_pkg;

    localparam int FBFS_ENTRIES   = 16;
    localparam int FBFS_SIZE_BITS = 32;
    localparam int FBFS_ID_BITS   = 16;

    localparam int CMD_W     = 2;
    localparam int IN_SIZE_W = 32;
    localparam int IN_ID_W   = 16;
    localparam int OUT_ID_W  = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]     command;
        logic [IN_SIZE_W-1:0] block_size;
        logic [IN_ID_W-1:0]   block_id;
        logic [IN_SIZE_W-1:0] request_size;
    } in_req_t;

    typedef struct packed {
        logic                first_found;
        logic [OUT_ID_W-1:0] first_id;
        logic                best_found;
        logic [OUT_ID_W-1:0] best_id;
        logic                worst_found;
        logic [OUT_ID_W-1:0] worst_id;
    } out_res_t;

    typedef struct packed {
        logic clear_count;
        logic append;
        logic start;
        logic rd_en;
        logic publish;
    } dp_cmd_t;

    typedef struct packed {
        logic empty;
        logic last_issue;
        logic out_full;
    } dp_status_t;

endpackage

// File: src/fbfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fbfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/fbfs_ctrl.sv
// Controller for the free block fit search: request decode and scan sequencing.
// Depends on fbfs_pkg.
module fbfs_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [fbfs_pkg::CMD_W-1:0] command,
    input  logic                   out_ready,
    input  fbfs_pkg::dp_status_t   status,
    output fbfs_pkg::dp_cmd_t      cmd
);
    import fbfs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (command)
                        CMD_CLEAR:  cmd.clear_count = 1'b1;
                        CMD_APPEND: cmd.append      = 1'b1;
                        CMD_QUERY:
                        begin
                            cmd.start  = 1'b1;
                            state_next = status.empty ? ST_FINISH : ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (status.last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!status.out_full || out_ready)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: src/fbfs_dp.sv
// Datapath for the free block fit search: block table, fit accumulators, result register.
// Depends on fbfs_pkg, fbfs_ram and free_block_fit_search_macros.svh.
`include "free_block_fit_search_macros.svh"

module fbfs_dp #(
    parameter int ENTRIES   = fbfs_pkg::FBFS_ENTRIES,
    parameter int SIZE_BITS = fbfs_pkg::FBFS_SIZE_BITS,
    parameter int ID_BITS   = fbfs_pkg::FBFS_ID_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fbfs_pkg::dp_cmd_t    cmd,
    input  fbfs_pkg::in_req_t    in_data,
    input  logic                 out_ready,
    output fbfs_pkg::dp_status_t status,
    output logic                 out_valid,
    output fbfs_pkg::out_res_t   out_data
);
    import fbfs_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int WW = SIZE_BITS + ID_BITS;

    logic [CW-1:0]        count_reg, count_next;
    logic [IW-1:0]        rd_addr_reg, rd_addr_next;
    logic                 dv_reg;
    logic [SIZE_BITS-1:0] req_reg;
    logic                 out_valid_reg, out_valid_next;
    out_res_t             out_data_reg;

    logic                 f_ok_reg, b_ok_reg, w_ok_reg;
    logic [ID_BITS-1:0]   f_id_reg, b_id_reg, w_id_reg;
    logic [SIZE_BITS-1:0] b_sz_reg, w_sz_reg;

    logic                 wr_en;
    logic [WW-1:0]        wr_data;
    logic [WW-1:0]        rd_data;
    logic [SIZE_BITS-1:0] s;
    logic [ID_BITS-1:0]   id;
    logic                 fits;

    assign wr_en   = cmd.append && (count_reg < CW'(ENTRIES));
    assign wr_data = {SIZE_BITS'(in_data.block_size), ID_BITS'(in_data.block_id)};

    fbfs_ram #(
        .WIDTH (WW),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IW-1:0]),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr_reg),
        .rd_data (rd_data)
    );

    assign s    = rd_data[WW-1:ID_BITS];
    assign id   = rd_data[ID_BITS-1:0];
    assign fits = dv_reg && !(s < req_reg);

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear_count)
        begin
            count_next = '0;
        end
        else if (wr_en)
        begin
            count_next = count_reg + CW'(1);
        end

        rd_addr_next = rd_addr_reg;
        if (cmd.start)
        begin
            rd_addr_next = '0;
        end
        else if (cmd.rd_en)
        begin
            rd_addr_next = rd_addr_reg + IW'(1);
        end

        out_valid_next = out_valid_reg;
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_addr_reg   <= '0;
            dv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            f_ok_reg      <= 1'b0;
            b_ok_reg      <= 1'b0;
            w_ok_reg      <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rd_addr_reg   <= rd_addr_next;
            dv_reg        <= cmd.rd_en;
            out_valid_reg <= out_valid_next;
            if (cmd.start)
            begin
                f_ok_reg <= 1'b0;
                b_ok_reg <= 1'b0;
                w_ok_reg <= 1'b0;
            end
            else if (fits)
            begin
                f_ok_reg <= 1'b1;
                b_ok_reg <= 1'b1;
                if (s != '0)
                begin
                    w_ok_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            req_reg  <= SIZE_BITS'(in_data.request_size);
            f_id_reg <= '0;
            b_id_reg <= '0;
            w_id_reg <= '0;
            b_sz_reg <= '0;
            w_sz_reg <= '0;
        end
        else if (fits)
        begin
            if (!f_ok_reg)
            begin
                f_id_reg <= id;
            end
            if (!b_ok_reg || (s < b_sz_reg))
            begin
                b_sz_reg <= s;
                b_id_reg <= id;
            end
            if ((s != '0) && (!w_ok_reg || (s > w_sz_reg)))
            begin
                w_sz_reg <= s;
                w_id_reg <= id;
            end
        end
        if (cmd.publish)
        begin
            out_data_reg.first_found <= f_ok_reg;
            out_data_reg.first_id    <= OUT_ID_W'(f_id_reg);
            out_data_reg.best_found  <= b_ok_reg;
            out_data_reg.best_id     <= OUT_ID_W'(b_id_reg);
            out_data_reg.worst_found <= w_ok_reg;
            out_data_reg.worst_id    <= OUT_ID_W'(w_id_reg);
        end
    end

    assign status.empty      = (count_reg == '0);
    assign status.last_issue = (CW'(rd_addr_reg) == (count_reg - CW'(1)));
    assign status.out_full   = out_valid_reg;
    assign out_valid         = out_valid_reg;
    assign out_data          = out_data_reg;

    `FBFS_ASSERT(a_rd_in_range, !cmd.rd_en || (CW'(rd_addr_reg) < count_reg), "read past count")
    `FBFS_ASSERT(a_wr_not_full, !wr_en || (count_reg < CW'(ENTRIES)), "append into full table")
    `FBFS_ASSERT(a_publish_free, !cmd.publish || !out_valid_reg || out_ready, "result overwritten")
    `FBFS_ASSERT(a_fit_flags, (f_ok_reg == b_ok_reg) && (!w_ok_reg || f_ok_reg), "fit flags disagree")
    `FBFS_ASSERT_NEXT(a_scan_static, cmd.rd_en, $stable(count_reg), "table changed during scan")

endmodule

// File: src/free_block_fit_search.sv
// Top level of the free block fit search: controller plus datapath.
// Depends on fbfs_pkg, fbfs_ctrl, fbfs_dp and fbfs_ram.
//
// Keeps up to ENTRIES free blocks (size, id) in order in a single-port-read RAM. A clear or
// append request is accepted in the idle state and gives no result; an append to a full table is
// dropped. A query reads the stored blocks one per cycle through the RAM read port, so it
// steps through the request, one read per block, the final compare and the result load (only
// the request and the result load on an empty table), and it waits before the result load if
// the previous result has not been taken yet. Results sit in an output register, so a new
// request may be accepted while a result waits.
module free_block_fit_search #(
    parameter int ENTRIES   = fbfs_pkg::FBFS_ENTRIES,
    parameter int SIZE_BITS = fbfs_pkg::FBFS_SIZE_BITS,
    parameter int ID_BITS   = fbfs_pkg::FBFS_ID_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  fbfs_pkg::in_req_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output fbfs_pkg::out_res_t out_data
);
    import fbfs_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    fbfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (in_data.command),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    fbfs_dp #(
        .ENTRIES   (ENTRIES),
        .SIZE_BITS (SIZE_BITS),
        .ID_BITS   (ID_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .out_ready (out_ready),
        .status    (status),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule
